// ----- hw/rtl/ads_pkg.sv -----
// ----------------------------------------------------------------------------
// ads_pkg
// Types, codes and constants shared by the array descriptor store modules.
// ----------------------------------------------------------------------------
package ads_pkg;

   localparam int MEM_BYTES_DEF = 65536;
   localparam int MAX_INDEX_DEF = 32767;

   localparam logic [2:0] HDR_ONE = 3'd5;
   localparam logic [2:0] HDR_TWO = 3'd7;

   localparam logic [15:0] RESET_BASE   = 16'd0;
   localparam logic [15:0] RESET_LIMIT  = 16'd65535;
   localparam logic [14:0] RESET_DEFMAX = 15'd10;

   localparam logic [1:0] KIND_DIM   = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   localparam logic [1:0] CSR_BASE   = 2'd0;
   localparam logic [1:0] CSR_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_DEFMAX = 2'd2;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_RANGE  = 3'd1;
   localparam logic [2:0] ST_DOUBLE = 3'd2;
   localparam logic [2:0] ST_NOMEM  = 3'd3;
   localparam logic [2:0] ST_SIZE   = 3'd4;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         name_first;
      logic [7:0]         name_second;
      logic signed [15:0] first_subscript;
      logic signed [15:0] second_subscript;
      logic [31:0]        write_data;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] read_data;
      logic [15:0] element_address;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_ACCEPT,
      OP_HSTART,
      OP_HRD,
      OP_SPAN_MUL,
      OP_SPAN_ADD,
      OP_CMUL,
      OP_CSTART,
      OP_CWR,
      OP_CEND,
      OP_AMUL,
      OP_ACHK,
      OP_ERD,
      OP_EWR,
      OP_SET_ST,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] st;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       size_bad;
      logic       walk_end;
      logic       name_hit;
      logic       hdr_last;
      logic       cwr_last;
      logic       nomem;
      logic       range_bad;
      logic       elem_last;
      logic       rsp_busy;
   } stat_type;

endpackage

// ----- hw/rtl/ads_ram.sv -----
// ----------------------------------------------------------------------------
// ads_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ads_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/ads_dp.sv -----
// ----------------------------------------------------------------------------
// ads_dp
// Datapath: registers, header walk, allocation, element access and byte RAM.
// ----------------------------------------------------------------------------
module ads_dp #(
   parameter int MEM_BYTES = ads_pkg::MEM_BYTES_DEF,
   parameter int MAX_INDEX = ads_pkg::MAX_INDEX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  ads_pkg::cmd_type cmd,
   output ads_pkg::stat_type stat,
   input  ads_pkg::req_type req_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ads_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(MEM_BYTES);
   localparam logic [16:0] MEM_LIM = 17'(MEM_BYTES);
   localparam logic signed [16:0] MAX_S = 17'(MAX_INDEX);

   ads_pkg::req_type  req_ff;
   ads_pkg::rsp_type  rsp_ff, rsp_in;
   logic              rsp_valid_ff;
   logic [15:0]       base_ff, limit_ff, alloc_ff;
   logic [14:0]       dm_ff;
   logic [16:0]       p_ff;
   logic [15:0]       cnt_ff, total_ff, elem_ff;
   logic              cap_en_ff;
   logic [6:0][7:0]   sh_ff;
   logic [33:0]       prod_ff;
   logic signed [15:0] cd1_ff, cd2_ff;
   logic [2:0]        st_ff;

   logic [16:0] mul_a, mul_b;
   logic [15:0] d1, d2, s1u, ram_base;
   logic        two, one_dim;
   logic [35:0] total;
   logic [16:0] limit_eff;
   logic [15:0] off;
   logic        bad;
   logic        ram_we;
   logic [7:0]  ram_wd, ram_q, cbyte;
   logic [15:0] ram_sum;

   assign d1      = {sh_ff[4], sh_ff[3]};
   assign d2      = {sh_ff[6], sh_ff[5]};
   assign one_dim = (sh_ff[2] == 8'd1);
   assign two     = !cd2_ff[15];
   assign s1u     = req_ff.first_subscript;

   always_comb begin
      unique case (cmd.op)
         ads_pkg::OP_SPAN_MUL: begin
            mul_a = {1'b0, d1} + 17'd1;
            mul_b = one_dim ? 17'd1 : ({1'b0, d2} + 17'd1);
         end
         ads_pkg::OP_CMUL: begin
            mul_a = {1'b0, cd1_ff} + 17'd1;
            mul_b = two ? ({1'b0, cd2_ff} + 17'd1) : 17'd1;
         end
         default: begin
            mul_a = {1'b0, s1u};
            mul_b = {1'b0, d2} + 17'd1;
         end
      endcase
   end

   assign total = 36'(two ? ads_pkg::HDR_TWO : ads_pkg::HDR_ONE) + {prod_ff, 2'b00};
   assign limit_eff = ({1'b0, limit_ff} < MEM_LIM) ? {1'b0, limit_ff} : MEM_LIM;

   always_comb begin
      bad = req_ff.first_subscript[15] || ({1'b0, s1u[14:0]} > d1);
      if (one_dim) begin
         bad = bad || !req_ff.second_subscript[15];
         off = 16'(ads_pkg::HDR_ONE) + {s1u[13:0], 2'b00};
      end else begin
         bad = bad || req_ff.second_subscript[15]
               || ({1'b0, req_ff.second_subscript[14:0]} > d2);
         off = 16'(ads_pkg::HDR_TWO)
               + {prod_ff[13:0] + req_ff.second_subscript[13:0], 2'b00};
      end
   end

   always_comb begin
      if (cnt_ff < 16'd5 || (cnt_ff < 16'd7 && two)) begin
         cbyte = sh_ff[cnt_ff[2:0]];
      end else begin
         cbyte = 8'd0;
      end
   end

   assign ram_base = (cmd.op == ads_pkg::OP_ERD || cmd.op == ads_pkg::OP_EWR)
                     ? elem_ff : p_ff[15:0];
   assign ram_we   = (cmd.op == ads_pkg::OP_CWR || cmd.op == ads_pkg::OP_EWR);
   assign ram_wd   = (cmd.op == ads_pkg::OP_EWR)
                     ? req_ff.write_data[{cnt_ff[1:0], 3'b000} +: 8] : cbyte;

   assign ram_sum = ram_base + cnt_ff;

   ads_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_sum[AW-1:0]),
      .wdata (ram_wd),
      .rdata (ram_q)
   );

   assign stat.kind      = req_ff.kind;
   assign stat.size_bad  = cd1_ff[15] || (17'(cd1_ff) > MAX_S) || (17'(cd2_ff) > MAX_S);
   assign stat.walk_end  = (p_ff >= {1'b0, alloc_ff});
   assign stat.name_hit  = (sh_ff[0] == req_ff.name_first) && (sh_ff[1] == req_ff.name_second);
   assign stat.hdr_last  = (cnt_ff == 16'd6);
   assign stat.cwr_last  = (cnt_ff == total_ff - 16'd1);
   assign stat.nomem     = ({20'd0, alloc_ff} + total) > {19'd0, limit_eff};
   assign stat.range_bad = bad;
   assign stat.elem_last = (cnt_ff == 16'd3);
   assign stat.rsp_busy  = rsp_valid_ff && rsp_stall;

   always_comb begin
      rsp_in.status          = st_ff;
      rsp_in.read_data       = 32'd0;
      rsp_in.element_address = 16'd0;
      if (st_ff == ads_pkg::ST_OK) begin
         if (req_ff.kind == ads_pkg::KIND_DIM) begin
            rsp_in.element_address = p_ff[15:0];
         end else if (req_ff.kind == ads_pkg::KIND_READ) begin
            rsp_in.element_address = elem_ff;
            rsp_in.read_data       = sh_ff[6:3];
         end else if (req_ff.kind == ads_pkg::KIND_WRITE) begin
            rsp_in.element_address = elem_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= ads_pkg::RESET_BASE;
         limit_ff     <= ads_pkg::RESET_LIMIT;
         dm_ff        <= ads_pkg::RESET_DEFMAX;
         alloc_ff     <= ads_pkg::RESET_BASE;
         rsp_valid_ff <= 1'b0;
         cap_en_ff    <= 1'b0;
      end else begin
         cap_en_ff <= (cmd.op == ads_pkg::OP_HRD || cmd.op == ads_pkg::OP_ERD);
         if (cmd.op == ads_pkg::OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               ads_pkg::CSR_BASE: begin
                  base_ff  <= csr_wdata;
                  alloc_ff <= csr_wdata;
               end
               ads_pkg::CSR_LIMIT:  limit_ff <= csr_wdata;
               ads_pkg::CSR_DEFMAX: dm_ff    <= csr_wdata[14:0];
               default: ;
            endcase
         end else if (cmd.op == ads_pkg::OP_CEND) begin
            alloc_ff <= alloc_ff + total_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cap_en_ff) begin
         sh_ff <= {ram_q, sh_ff[6:1]};
      end
      unique case (cmd.op)
         ads_pkg::OP_ACCEPT: begin
            req_ff <= req_data;
            p_ff   <= {1'b0, base_ff};
            st_ff  <= ads_pkg::ST_OK;
            if (req_data.kind == ads_pkg::KIND_DIM) begin
               cd1_ff <= req_data.first_subscript;
               cd2_ff <= req_data.second_subscript;
            end else begin
               cd1_ff <= {1'b0, dm_ff};
               cd2_ff <= req_data.second_subscript[15] ? 16'hFFFF : {1'b0, dm_ff};
            end
         end
         ads_pkg::OP_HSTART: cnt_ff <= 16'd0;
         ads_pkg::OP_HRD:    cnt_ff <= cnt_ff + 16'd1;
         ads_pkg::OP_SPAN_MUL, ads_pkg::OP_CMUL, ads_pkg::OP_AMUL: prod_ff <= mul_a * mul_b;
         ads_pkg::OP_SPAN_ADD: begin
            p_ff <= p_ff + 17'(ads_pkg::HDR_TWO) - (one_dim ? 17'd2 : 17'd0)
                    + {prod_ff[14:0], 2'b00};
         end
         ads_pkg::OP_CSTART: begin
            cnt_ff   <= 16'd0;
            total_ff <= total[15:0];
            p_ff     <= {1'b0, alloc_ff};
            sh_ff    <= {cd2_ff[15:8], cd2_ff[7:0], cd1_ff[15:8], cd1_ff[7:0],
                         (two ? 8'd2 : 8'd1), req_ff.name_second, req_ff.name_first};
         end
         ads_pkg::OP_CWR: cnt_ff <= cnt_ff + 16'd1;
         ads_pkg::OP_ACHK: begin
            cnt_ff  <= 16'd0;
            elem_ff <= p_ff[15:0] + off;
            if (bad) begin
               st_ff <= ads_pkg::ST_RANGE;
            end
         end
         ads_pkg::OP_ERD, ads_pkg::OP_EWR: cnt_ff <= cnt_ff + 16'd1;
         ads_pkg::OP_SET_ST: st_ff <= cmd.st;
         ads_pkg::OP_EMIT:   rsp_ff <= rsp_in;
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hw/rtl/ads_ctrl.sv -----
// ----------------------------------------------------------------------------
// ads_ctrl
// Controller state machine sequencing lookup, creation and element access.
// ----------------------------------------------------------------------------
module ads_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ads_pkg::stat_type stat,
   output ads_pkg::cmd_type  cmd
);

   typedef enum logic [16:0] {
      S_IDLE   = 17'h00001,
      S_CHECK  = 17'h00002,
      S_LTEST  = 17'h00004,
      S_HDR    = 17'h00008,
      S_HWAIT  = 17'h00010,
      S_HCMP   = 17'h00020,
      S_SPAN   = 17'h00040,
      S_CMUL   = 17'h00080,
      S_CCHK   = 17'h00100,
      S_CWR    = 17'h00200,
      S_CEND   = 17'h00400,
      S_AMUL   = 17'h00800,
      S_ACHK   = 17'h01000,
      S_ERD    = 17'h02000,
      S_EWAIT  = 17'h04000,
      S_EWR    = 17'h08000,
      S_DONE   = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = ads_pkg::OP_IDLE;
      cmd.st   = ads_pkg::ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = ads_pkg::OP_ACCEPT;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.kind == ads_pkg::KIND_NONE) begin
               state_in = S_DONE;
            end else if (stat.kind == ads_pkg::KIND_DIM && stat.size_bad) begin
               cmd.op   = ads_pkg::OP_SET_ST;
               cmd.st   = ads_pkg::ST_SIZE;
               state_in = S_DONE;
            end else begin
               state_in = S_LTEST;
            end
         end
         S_LTEST: begin
            if (!stat.walk_end) begin
               cmd.op   = ads_pkg::OP_HSTART;
               state_in = S_HDR;
            end else if (stat.size_bad) begin
               cmd.op   = ads_pkg::OP_SET_ST;
               cmd.st   = ads_pkg::ST_SIZE;
               state_in = S_DONE;
            end else begin
               state_in = S_CMUL;
            end
         end
         S_HDR: begin
            cmd.op = ads_pkg::OP_HRD;
            if (stat.hdr_last) begin
               state_in = S_HWAIT;
            end
         end
         S_HWAIT: state_in = S_HCMP;
         S_HCMP: begin
            if (!stat.name_hit) begin
               cmd.op   = ads_pkg::OP_SPAN_MUL;
               state_in = S_SPAN;
            end else if (stat.kind == ads_pkg::KIND_DIM) begin
               cmd.op   = ads_pkg::OP_SET_ST;
               cmd.st   = ads_pkg::ST_DOUBLE;
               state_in = S_DONE;
            end else begin
               cmd.op   = ads_pkg::OP_AMUL;
               state_in = S_ACHK;
            end
         end
         S_SPAN: begin
            cmd.op   = ads_pkg::OP_SPAN_ADD;
            state_in = S_LTEST;
         end
         S_CMUL: begin
            cmd.op   = ads_pkg::OP_CMUL;
            state_in = S_CCHK;
         end
         S_CCHK: begin
            if (stat.nomem) begin
               cmd.op   = ads_pkg::OP_SET_ST;
               cmd.st   = ads_pkg::ST_NOMEM;
               state_in = S_DONE;
            end else begin
               cmd.op   = ads_pkg::OP_CSTART;
               state_in = S_CWR;
            end
         end
         S_CWR: begin
            cmd.op = ads_pkg::OP_CWR;
            if (stat.cwr_last) begin
               state_in = S_CEND;
            end
         end
         S_CEND: begin
            cmd.op   = ads_pkg::OP_CEND;
            state_in = (stat.kind == ads_pkg::KIND_DIM) ? S_DONE : S_AMUL;
         end
         S_AMUL: begin
            cmd.op   = ads_pkg::OP_AMUL;
            state_in = S_ACHK;
         end
         S_ACHK: begin
            cmd.op = ads_pkg::OP_ACHK;
            if (stat.range_bad) begin
               state_in = S_DONE;
            end else if (stat.kind == ads_pkg::KIND_READ) begin
               state_in = S_ERD;
            end else begin
               state_in = S_EWR;
            end
         end
         S_ERD: begin
            cmd.op = ads_pkg::OP_ERD;
            if (stat.elem_last) begin
               state_in = S_EWAIT;
            end
         end
         S_EWAIT: state_in = S_DONE;
         S_EWR: begin
            cmd.op = ads_pkg::OP_EWR;
            if (stat.elem_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.op   = ads_pkg::OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ----- hw/rtl/array_descriptor_store_top.sv -----
// ----------------------------------------------------------------------------
// array_descriptor_store_top
// Array header store in a byte RAM: dimension, element read, element write.
// ----------------------------------------------------------------------------
// One request at a time; the input stalls from the accept until the response
// is loaded. The single-port byte RAM sets the cost of each request: the
// walk from region_base reads 7 header bytes of each array header that it
// passes over and of the matching one. Creation writes each header and
// element byte in turn (5 or 7 plus 4 per element). An element access moves
// its four bytes in turn. The response waits while the previous response is
// stalled. No clearing pass after reset. Writing region_base empties the
// region.
module array_descriptor_store_top #(
   parameter int MEM_BYTES = ads_pkg::MEM_BYTES_DEF,
   parameter int MAX_INDEX = ads_pkg::MAX_INDEX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ads_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ads_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   ads_pkg::cmd_type  cmd;
   ads_pkg::stat_type stat;

   ads_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ads_dp #(.MEM_BYTES(MEM_BYTES), .MAX_INDEX(MAX_INDEX)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/array_descriptor_store_checker.sv -----
// ----------------------------------------------------------------------------
// array_descriptor_store_checker
// Watches the request, response and register ports of the array descriptor
// store, keeps its own copy of the byte memory and allocation pointer,
// predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module array_descriptor_store_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  ads_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  ads_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_IDX = ads_pkg::MAX_INDEX_DEF;

   logic [7:0]       byte_mem [int];
   int               base_addr, limit_addr, default_max, alloc_ptr;
   ads_pkg::rsp_type expected_rsp [$];

   function automatic int rd8(longint a);
      int k;
      k = int'(a % ads_pkg::MEM_BYTES_DEF);
      return byte_mem.exists(k) ? int'(byte_mem[k]) : 0;
   endfunction

   function automatic void wr8(longint a, logic [7:0] v);
      byte_mem[int'(a % ads_pkg::MEM_BYTES_DEF)] = v;
   endfunction

   function automatic int rd16(longint a);
      return rd8(a) | (rd8(a + 1) << 8);
   endfunction

   function automatic longint span_at(longint h);
      longint d1;
      d1 = rd16(h + 3) + 1;
      if (rd8(h + 2) == 1) begin
         return ads_pkg::HDR_ONE + d1 * 4;
      end
      return ads_pkg::HDR_TWO + d1 * (rd16(h + 5) + 1) * 4;
   endfunction

   function automatic bit find_array(logic [7:0] n0, logic [7:0] n1, output longint where);
      longint p;
      p = base_addr;
      where = 0;
      while (p < alloc_ptr) begin
         if (rd8(p) == n0 && rd8(p + 1) == n1) begin
            where = p;
            return 1;
         end
         p += span_at(p);
      end
      return 0;
   endfunction

   function automatic logic [2:0] make_array(logic [7:0] n0, logic [7:0] n1, int d1, int d2,
                                             output longint where);
      longint hdr, total, lim, p;
      bit     two;
      two = d2 >= 0;
      where = 0;
      if (d1 < 0 || d1 > MAX_IDX || d2 > MAX_IDX) return ads_pkg::ST_SIZE;
      if (find_array(n0, n1, p)) return ads_pkg::ST_DOUBLE;
      hdr = two ? ads_pkg::HDR_TWO : ads_pkg::HDR_ONE;
      total = longint'(d1) + 1;
      if (two) total *= longint'(d2) + 1;
      total = hdr + total * 4;
      lim = limit_addr < ads_pkg::MEM_BYTES_DEF ? limit_addr : ads_pkg::MEM_BYTES_DEF;
      if (alloc_ptr + total > lim) return ads_pkg::ST_NOMEM;
      p = alloc_ptr;
      wr8(p, n0);
      wr8(p + 1, n1);
      wr8(p + 2, two ? 8'd2 : 8'd1);
      wr8(p + 3, d1[7:0]);
      wr8(p + 4, d1[15:8]);
      if (two) begin
         wr8(p + 5, d2[7:0]);
         wr8(p + 6, d2[15:8]);
      end
      for (longint i = hdr; i < total; i++) wr8(p + i, 8'h00);
      alloc_ptr = int'((p + total) & 16'hFFFF);
      where = p;
      return ads_pkg::ST_OK;
   endfunction

   function automatic ads_pkg::rsp_type predict_access(ads_pkg::req_type r);
      ads_pkg::rsp_type res;
      longint  arr, off, elem;
      int      s1, s2, d1, d2;
      res = '0;
      arr = 0;
      off = 0;
      s1 = int'(r.first_subscript);
      s2 = int'(r.second_subscript);
      if (r.kind == ads_pkg::KIND_DIM) begin
         res.status = make_array(r.name_first, r.name_second, s1, s2, arr);
         if (res.status == ads_pkg::ST_OK) res.element_address = arr[15:0];
      end else if (r.kind == ads_pkg::KIND_READ || r.kind == ads_pkg::KIND_WRITE) begin
         if (!find_array(r.name_first, r.name_second, arr))
            res.status = make_array(r.name_first, r.name_second, default_max,
                                    s2 >= 0 ? default_max : -1, arr);
         if (res.status == ads_pkg::ST_OK) begin
            d1 = rd16(arr + 3);
            if (s1 < 0 || s1 > d1) begin
               res.status = ads_pkg::ST_RANGE;
            end else if (rd8(arr + 2) == 1) begin
               if (s2 >= 0) res.status = ads_pkg::ST_RANGE;
               off = ads_pkg::HDR_ONE + longint'(s1) * 4;
            end else begin
               d2 = rd16(arr + 5);
               if (s2 < 0 || s2 > d2) res.status = ads_pkg::ST_RANGE;
               off = ads_pkg::HDR_TWO + (longint'(s1) * (d2 + 1) + (s2 < 0 ? 0 : s2)) * 4;
            end
            if (res.status == ads_pkg::ST_OK) begin
               elem = arr + off;
               res.element_address = elem[15:0];
               if (r.kind == ads_pkg::KIND_READ) begin
                  for (int b = 0; b < 4; b++) res.read_data[8*b +: 8] = 8'(rd8(elem + b));
               end else begin
                  for (int b = 0; b < 4; b++) wr8(elem + b, r.write_data[8*b +: 8]);
               end
            end
         end
      end
      return res;
   endfunction

   assign pending_count = expected_rsp.size();

   always @(posedge clock) begin
      ads_pkg::rsp_type want;
      if (reset) begin
         base_addr   = ads_pkg::RESET_BASE;
         limit_addr  = ads_pkg::RESET_LIMIT;
         default_max = ads_pkg::RESET_DEFMAX;
         alloc_ptr   = ads_pkg::RESET_BASE;
         fail_count  <= 0;
         expected_rsp.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               ads_pkg::CSR_BASE: begin
                  base_addr = csr_wdata;
                  alloc_ptr = csr_wdata;
               end
               ads_pkg::CSR_LIMIT: limit_addr = csr_wdata;
               ads_pkg::CSR_DEFMAX: default_max = csr_wdata[14:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_rsp.push_back(predict_access(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               if (fail_count < 10) $display("unexpected response transfer: %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status || rsp_data.read_data !== want.read_data ||
                   rsp_data.element_address !== want.element_address) begin
                  if (fail_count < 10)
                     $display("mismatch: expected status %0d data %h addr %h, got %0d %h %h",
                              want.status, want.read_data, want.element_address,
                              rsp_data.status, rsp_data.read_data, rsp_data.element_address);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- tb/array_descriptor_store_top_tb.sv -----
// ----------------------------------------------------------------------------
// array_descriptor_store_top_tb
// Drives dimension, read, write and no-op requests into the array descriptor store
// through several register settings with random idling on both sides and
// one long response hold-off; the checker predicts and compares responses.
// ----------------------------------------------------------------------------
module array_descriptor_store_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   ads_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   ads_pkg::rsp_type rsp_data;
   logic             csr_we;
   logic [1:0]       csr_index;
   logic [15:0]      csr_wdata;
   int               fail_count;
   int               pending_count;
   int               tx_idle_pct;
   int               rx_idle_pct;
   bit               hold_off_req;
   logic [7:0]       name_pool [8][2];

   array_descriptor_store_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   array_descriptor_store_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Verification failed");
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (600) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   task automatic send_request(logic [1:0] kind, logic [7:0] n0, logic [7:0] n1,
                               logic [15:0] s1, logic [15:0] s2, logic [31:0] wd);
      int gap;
      gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{kind, n0, n1, s1, s2, wd};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic send_random(int count);
      logic [1:0]  kind;
      logic [7:0]  n0, n1;
      logic [15:0] s1, s2;
      int          pick, sel;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         kind = (pick < 20) ? ads_pkg::KIND_DIM : (pick < 58) ? ads_pkg::KIND_READ :
                (pick < 97) ? ads_pkg::KIND_WRITE : ads_pkg::KIND_NONE;
         sel = $urandom_range(7);
         n0 = name_pool[sel][0];
         n1 = name_pool[sel][1];
         if ($urandom_range(99) < 2) begin
            n0 = 8'($urandom);
            n1 = 8'($urandom);
         end
         pick = $urandom_range(99);
         if (pick < 85) begin
            s1 = 16'($urandom_range(0, kind == ads_pkg::KIND_DIM ? 8 : 12));
            s2 = ($urandom_range(1) != 0) ? 16'hFFFF : 16'($urandom_range(0, 6));
         end else if (pick < 93) begin
            s1 = 16'($urandom);
            s2 = 16'($urandom);
         end else begin
            s1 = ($urandom_range(1) != 0) ? 16'h7FFF : 16'hFFFF;
            s2 = ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
         end
         send_request(kind, n0, n1, s1, s2, $urandom);
      end
   endtask

   initial begin
      int seg_base;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_we       = 1'b0;
      csr_index    = ads_pkg::CSR_BASE;
      csr_wdata    = '0;
      tx_idle_pct  = 32;
      rx_idle_pct  = 70;
      hold_off_req = 1'b0;
      reset        = 1'b1;
      for (int i = 0; i < 8; i++) begin
         name_pool[i][0] = 8'h41 + i[7:0];
         name_pool[i][1] = (i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'h80 : 8'h39;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send_request(ads_pkg::KIND_DIM,   8'h41, 8'h00, 16'd3, 16'hFFFF, 32'h0);
      send_request(ads_pkg::KIND_DIM,   8'h41, 8'h00, 16'd1, 16'hFFFF, 32'h0);
      send_request(ads_pkg::KIND_DIM,   8'h42, 8'h80, 16'd2, 16'd3, 32'h0);
      send_request(ads_pkg::KIND_DIM,   8'h43, 8'h00, 16'hFFFF, 16'hFFFF, 32'h0);
      send_request(ads_pkg::KIND_DIM,   8'hFF, 8'hFF, 16'h7FFF, 16'h7FFF, 32'h0);
      send_request(ads_pkg::KIND_WRITE, 8'h41, 8'h00, 16'd0, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(ads_pkg::KIND_WRITE, 8'h41, 8'h00, 16'd3, 16'hFFFF, 32'hA5C3_0F96);
      send_request(ads_pkg::KIND_READ,  8'h41, 8'h00, 16'd0, 16'hFFFF, 32'h0);
      send_request(ads_pkg::KIND_READ,  8'h41, 8'h00, 16'd3, 16'h8000, 32'h0);
      send_request(ads_pkg::KIND_READ,  8'h41, 8'h00, 16'd4, 16'hFFFF, 32'h0);
      send_request(ads_pkg::KIND_READ,  8'h41, 8'h00, 16'd0, 16'd0, 32'h0);
      send_request(ads_pkg::KIND_WRITE, 8'h42, 8'h80, 16'd2, 16'd3, 32'h1234_5678);
      send_request(ads_pkg::KIND_READ,  8'h42, 8'h80, 16'd2, 16'd3, 32'h0);
      send_request(ads_pkg::KIND_READ,  8'h42, 8'h80, 16'd1, 16'hFFFF, 32'h0);
      send_request(ads_pkg::KIND_READ,  8'h42, 8'h80, 16'd0, 16'd4, 32'h0);
      send_request(ads_pkg::KIND_READ,  8'h41, 8'h00, 16'hFFFF, 16'hFFFF, 32'h0);
      send_request(ads_pkg::KIND_READ,  8'h41, 8'h00, 16'h7FFF, 16'hFFFF, 32'h0);
      send_request(ads_pkg::KIND_WRITE, 8'h44, 8'h39, 16'd10, 16'hFFFF, 32'h0000_0001);
      send_request(ads_pkg::KIND_READ,  8'h45, 8'h00, 16'd2, 16'd7, 32'h0);
      send_request(ads_pkg::KIND_READ,  8'h00, 8'h00, 16'd0, 16'hFFFF, 32'h0);
      send_request(ads_pkg::KIND_NONE,  8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      drain_block();

      write_reg(ads_pkg::CSR_LIMIT, 16'd0);
      write_reg(ads_pkg::CSR_DEFMAX, 16'd0);
      send_request(ads_pkg::KIND_DIM,   8'h41, 8'h00, 16'd0, 16'hFFFF, 32'h0);
      send_request(ads_pkg::KIND_READ,  8'h46, 8'h00, 16'd0, 16'hFFFF, 32'h0);
      drain_block();
      write_reg(ads_pkg::CSR_DEFMAX, 16'h7FFF);
      write_reg(ads_pkg::CSR_LIMIT, 16'hFFFF);
      write_reg(ads_pkg::CSR_BASE, 16'hFF00);
      send_request(ads_pkg::KIND_WRITE, 8'h47, 8'h00, 16'd0, 16'hFFFF, 32'h0);
      send_request(ads_pkg::KIND_DIM,   8'h47, 8'h00, 16'd40, 16'hFFFF, 32'h0);
      send_request(ads_pkg::KIND_DIM,   8'h48, 8'h00, 16'd60, 16'hFFFF, 32'h0);
      drain_block();

      for (int seg = 0; seg < 6; seg++) begin
         tx_idle_pct = (seg < 2) ? 32 : (seg < 4) ? 70 : 0;
         rx_idle_pct = (seg < 2) ? 70 : (seg < 4) ? 32 : 0;
         case (seg)
            0: begin
               write_reg(ads_pkg::CSR_BASE, 16'd0);
               write_reg(ads_pkg::CSR_LIMIT, 16'hFFFF);
               write_reg(ads_pkg::CSR_DEFMAX, 16'd10);
            end
            1: begin
               write_reg(ads_pkg::CSR_BASE, 16'd60000);
               write_reg(ads_pkg::CSR_LIMIT, 16'hFFFF);
               write_reg(ads_pkg::CSR_DEFMAX, 16'd0);
            end
            default: begin
               seg_base = $urandom_range(0, 40000);
               write_reg(ads_pkg::CSR_BASE, 16'(seg_base));
               write_reg(ads_pkg::CSR_LIMIT, 16'(seg_base + $urandom_range(300, 20000)));
               write_reg(ads_pkg::CSR_DEFMAX, 16'($urandom_range(0, 16)));
            end
         endcase
         if (seg == 4) hold_off_req = 1'b1;
         send_random(320);
         drain_block();
      end

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
